// File: hdl/euler_fly_camera_update_macros.svh
`ifndef EULER_FLY_CAMERA_UPDATE_MACROS_SVH
`define EULER_FLY_CAMERA_UPDATE_MACROS_SVH

// same-cycle implication
`define EFCU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EFCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/efcu_pkg.sv
`default_nettype none
package efcu_pkg;

  localparam int MUL_W = 33;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int PITCH_LIMIT_DEG_DEF = 89;

  localparam int HALF_TURN    = 23040;
  localparam int FULL_TURN    = 46080;
  localparam int FOLD_LIMIT   = 11520;
  localparam int INV_GAIN_Q30 = 652032875;

  localparam int IN_DATA_W  = 152;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 240;

  localparam logic [1:0] FUNC_MOVE  = 2'd0;
  localparam logic [1:0] FUNC_LOOK  = 2'd1;
  localparam logic [1:0] FUNC_PLACE = 2'd2;

  localparam logic [1:0] DIR_BACK  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [2:0] CFG_MOVE_SPEED  = 3'd0;
  localparam logic [2:0] CFG_LOOK_SENS   = 3'd1;
  localparam logic [2:0] CFG_WORLD_UP_X  = 3'd2;
  localparam logic [2:0] CFG_WORLD_UP_Y  = 3'd3;
  localparam logic [2:0] CFG_WORLD_UP_Z  = 3'd4;
  localparam logic [2:0] CFG_PITCH_CLAMP = 3'd5;
  localparam logic [2:0] CFG_START_YAW   = 3'd6;
  localparam logic [2:0] CFG_START_PITCH = 3'd7;

  // atan(2^-i) in degrees, Q22
  function automatic logic signed [31:0] atan_q22(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:  r = 32'sd188743680;
      5'd1:  r = 32'sd111421900;
      5'd2:  r = 32'sd58872272;
      5'd3:  r = 32'sd29884485;
      5'd4:  r = 32'sd15000234;
      5'd5:  r = 32'sd7507429;
      5'd6:  r = 32'sd3754631;
      5'd7:  r = 32'sd1877430;
      5'd8:  r = 32'sd938729;
      5'd9:  r = 32'sd469366;
      5'd10: r = 32'sd234683;
      5'd11: r = 32'sd117342;
      5'd12: r = 32'sd58671;
      5'd13: r = 32'sd29335;
      5'd14: r = 32'sd14668;
      5'd15: r = 32'sd7334;
      5'd16: r = 32'sd3667;
      5'd17: r = 32'sd1833;
      5'd18: r = 32'sd917;
      5'd19: r = 32'sd458;
      5'd20: r = 32'sd229;
      5'd21: r = 32'sd115;
      5'd22: r = 32'sd57;
      5'd23: r = 32'sd29;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/euler_fly_camera_update.sv
`default_nettype none
`include "euler_fly_camera_update_macros.svh"
// Euler-angle fly camera. One event per input beat (tuser: 0 move, 1 look,
// 2 place, 3 no-op), one result beat per event holding position and the
// front/right/up basis. A single 33x33 multiplier, a CORDIC stage, a
// two-bit-per-cycle square root and a restoring divider are sequenced one
// step per cycle, and in_tready stays low while an event is in work. Look
// and place also bring yaw and pitch into range (pitch is clamped when
// enabled) and run three normalizations, dominated by the 32-step square
// root and 15-step divides.
module euler_fly_camera_update #(
  parameter int CORDIC_STEPS    = efcu_pkg::CORDIC_STEPS_DEF,
  parameter int PITCH_LIMIT_DEG = efcu_pkg::PITCH_LIMIT_DEG_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [2:0]                      cfg_addr,
  input  wire logic [15:0]                     cfg_wdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // direction, delta_time, look_dx, look_dy, place_x, place_y, place_z
  input  wire logic [efcu_pkg::IN_DATA_W-1:0]  in_tdata,
  // func
  input  wire logic [efcu_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // cam_x, cam_y, cam_z, front_x/y/z, right_x/y/z, up_x/y/z
  output logic [efcu_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import efcu_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MV0  = 5'd1;
  localparam logic [4:0] S_MV1  = 5'd2;
  localparam logic [4:0] S_MV2  = 5'd3;
  localparam logic [4:0] S_MV3  = 5'd4;
  localparam logic [4:0] S_LK0  = 5'd5;
  localparam logic [4:0] S_LK1  = 5'd6;
  localparam logic [4:0] S_LK2  = 5'd7;
  localparam logic [4:0] S_LK3  = 5'd8;
  localparam logic [4:0] S_ANG  = 5'd9;
  localparam logic [4:0] S_WRAP = 5'd10;
  localparam logic [4:0] S_CS0  = 5'd11;
  localparam logic [4:0] S_CS1  = 5'd12;
  localparam logic [4:0] S_CS2  = 5'd13;
  localparam logic [4:0] S_FR0  = 5'd14;
  localparam logic [4:0] S_FR1  = 5'd15;
  localparam logic [4:0] S_FR2  = 5'd16;
  localparam logic [4:0] S_NSQ  = 5'd17;
  localparam logic [4:0] S_NAC  = 5'd18;
  localparam logic [4:0] S_SQ   = 5'd19;
  localparam logic [4:0] S_DV0  = 5'd20;
  localparam logic [4:0] S_DV1  = 5'd21;
  localparam logic [4:0] S_DV2  = 5'd22;
  localparam logic [4:0] S_CRM  = 5'd23;
  localparam logic [4:0] S_CRA  = 5'd24;
  localparam logic [4:0] S_DONE = 5'd25;

  localparam logic signed [31:0] PITCH_LIM = 32'(PITCH_LIMIT_DEG * 128);
  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  logic [4:0] st_r;

  logic [15:0]        speed_r, sens_r;
  logic signed [15:0] wu_r [3];
  logic               clamp_en_r;
  logic signed [15:0] syaw_r;
  logic signed [14:0] spitch_r;

  logic [1:0]         func_r, dir_r;
  logic [15:0]        dt_r;
  logic signed [15:0] dx_r, dy_r;

  logic signed [31:0] pos_r [3];
  logic signed [15:0] yaw_r, pitch_r;
  logic signed [15:0] front_r [3];
  logic signed [15:0] right_r [3];
  logic signed [15:0] up_r [3];

  logic [31:0]        shift_r;
  logic [1:0]         k_r, nsel_r;
  logic [2:0]         j_r;
  logic               aflag_r, cflag_r, neg_r;
  logic signed [31:0] av_r;
  logic [31:0]        wr_r;
  logic signed [32:0] wx_r, wy_r;
  logic signed [31:0] wz_r;
  logic signed [32:0] cosy_r, siny_r, cosp_r, sinp_r;
  logic signed [31:0] vec_r [3];
  logic [63:0]        sum_r, sqn_r, sqres_r;
  logic [31:0]        len_r;
  logic [46:0]        rem_r;
  logic [14:0]        q_r;
  logic signed [31:0] acc_r;
  logic [4:0]         cnt_r;

  logic               out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;

  efcu_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // move component and cross operands
  logic signed [15:0] mv_c;
  logic               mv_neg;
  logic signed [15:0] cr_a [3];
  logic signed [15:0] cr_b [3];
  logic signed [15:0] cr_x, cr_y;

  always_comb begin
    mv_c   = (dir_r == DIR_LEFT || dir_r == DIR_RIGHT) ? right_r[k_r] : front_r[k_r];
    mv_neg = (dir_r == DIR_BACK || dir_r == DIR_LEFT);
    for (int i = 0; i < 3; i++) begin
      cr_a[i] = (nsel_r == 2'd0) ? front_r[i] : right_r[i];
      cr_b[i] = (nsel_r == 2'd0) ? wu_r[i] : front_r[i];
    end
    case (j_r)
      3'd0:    begin cr_x = cr_a[1]; cr_y = cr_b[2]; end
      3'd1:    begin cr_x = cr_a[2]; cr_y = cr_b[1]; end
      3'd2:    begin cr_x = cr_a[2]; cr_y = cr_b[0]; end
      3'd3:    begin cr_x = cr_a[0]; cr_y = cr_b[2]; end
      3'd4:    begin cr_x = cr_a[0]; cr_y = cr_b[1]; end
      default: begin cr_x = cr_a[1]; cr_y = cr_b[0]; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      S_MV0: begin
        mul_a = $signed({17'd0, speed_r});
        mul_b = $signed({17'd0, dt_r});
      end
      S_MV2: begin
        mul_a = mv_neg ? -MUL_W'(mv_c) : MUL_W'(mv_c);
        mul_b = $signed({1'b0, shift_r});
      end
      S_LK0: begin
        mul_a = MUL_W'(dx_r);
        mul_b = $signed({17'd0, sens_r});
      end
      S_LK2: begin
        mul_a = MUL_W'(dy_r);
        mul_b = $signed({17'd0, sens_r});
      end
      S_FR0: begin
        mul_a = cosy_r;
        mul_b = cosp_r;
      end
      S_FR1: begin
        mul_a = siny_r;
        mul_b = cosp_r;
      end
      S_NSQ: begin
        mul_a = $signed({1'b0, mag32(vec_r[k_r])});
        mul_b = $signed({1'b0, mag32(vec_r[k_r])});
      end
      S_CRM: begin
        mul_a = MUL_W'(cr_x);
        mul_b = MUL_W'(cr_y);
      end
      default: ;
    endcase
  end

  // angle limit / wrap
  logic [31:0]        wtrial, wr_nxt;
  logic signed [31:0] clamp_v;
  logic               ang_done;
  logic signed [15:0] ang_res;

  always_comb begin
    wtrial = 32'(FULL_TURN) << cnt_r[3:0];
    wr_nxt = (wr_r >= wtrial) ? wr_r - wtrial : wr_r;
    if (av_r > PITCH_LIM) clamp_v = PITCH_LIM;
    else if (av_r < -PITCH_LIM) clamp_v = -PITCH_LIM;
    else clamp_v = av_r;
    ang_done = 1'b0;
    ang_res  = '0;
    if (st_r == S_ANG && aflag_r && clamp_en_r) begin
      ang_done = 1'b1;
      ang_res  = 16'(clamp_v);
    end else if (st_r == S_WRAP && cnt_r == 5'd0) begin
      ang_done = 1'b1;
      ang_res  = 16'(wr_nxt - 32'(HALF_TURN));
    end
  end

  // CORDIC step
  logic signed [32:0] cx_sh, cy_sh;
  logic signed [31:0] atan_v;
  logic signed [15:0] ang_in;
  logic signed [16:0] ang_f;
  logic               ang_neg;

  always_comb begin
    cx_sh  = wx_r >>> cnt_r;
    cy_sh  = wy_r >>> cnt_r;
    atan_v = atan_q22(cnt_r);
    ang_in = cflag_r ? pitch_r : yaw_r;
    if (ang_in > 16'(FOLD_LIMIT)) begin
      ang_f   = 17'(ang_in) - 17'(HALF_TURN);
      ang_neg = 1'b1;
    end else if (ang_in < -16'(FOLD_LIMIT)) begin
      ang_f   = 17'(ang_in) + 17'(HALF_TURN);
      ang_neg = 1'b1;
    end else begin
      ang_f   = 17'(ang_in);
      ang_neg = 1'b0;
    end
  end

  // square root and division steps
  logic [63:0] sq_bit, sq_t, sqn_nxt, sqres_nxt;
  logic [46:0] dv_trial;
  logic [31:0] vmag;

  always_comb begin
    sq_bit = 64'd1 << {cnt_r, 1'b0};
    sq_t   = sqres_r + sq_bit;
    if (sqn_r >= sq_t) begin
      sqn_nxt   = sqn_r - sq_t;
      sqres_nxt = (sqres_r >> 1) + sq_bit;
    end else begin
      sqn_nxt   = sqn_r;
      sqres_nxt = sqres_r >> 1;
    end
    dv_trial = 47'(len_r) << cnt_r[3:0];
    vmag     = mag32(vec_r[k_r]);
  end

  logic signed [33:0] mv_sum;
  logic signed [31:0] mv_r, lk_r, fr_r;
  logic signed [15:0] nq;

  always_comb begin
    mv_r   = 32'((prod + (66'sd1 <<< 21)) >>> 22);
    lk_r   = 32'((prod + 66'sd4) >>> 3);
    fr_r   = 32'((prod + (66'sd1 <<< 29)) >>> 30);
    mv_sum = 34'(pos_r[k_r]) + 34'(mv_r);
    nq     = vec_r[k_r][31] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      out_tvalid_r <= 1'b0;
      speed_r      <= 16'd2560;
      sens_r       <= 16'd102;
      wu_r[0]      <= 16'sd0;
      wu_r[1]      <= 16'sd16384;
      wu_r[2]      <= 16'sd0;
      clamp_en_r   <= 1'b1;
      syaw_r       <= '0;
      spitch_r     <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i]   <= '0;
        front_r[i] <= '0;
        right_r[i] <= '0;
        up_r[i]    <= '0;
      end
      front_r[0] <= 16'sd16384;
      right_r[2] <= 16'sd16384;
      up_r[1]    <= 16'sd16384;
      yaw_r      <= '0;
      pitch_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_MOVE_SPEED:  speed_r    <= cfg_wdata;
          CFG_LOOK_SENS:   sens_r     <= cfg_wdata;
          CFG_WORLD_UP_X:  wu_r[0]    <= $signed(cfg_wdata);
          CFG_WORLD_UP_Y:  wu_r[1]    <= $signed(cfg_wdata);
          CFG_WORLD_UP_Z:  wu_r[2]    <= $signed(cfg_wdata);
          CFG_PITCH_CLAMP: clamp_en_r <= cfg_wdata[0];
          CFG_START_YAW:   syaw_r     <= $signed(cfg_wdata);
          CFG_START_PITCH: spitch_r   <= $signed(cfg_wdata[14:0]);
          default: ;
        endcase
      end

      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;

      if (ang_done) begin
        if (!aflag_r) begin
          yaw_r <= ang_res;
          if (func_r == FUNC_LOOK) begin
            st_r <= S_LK2;
          end else begin
            av_r    <= 32'(spitch_r);
            aflag_r <= 1'b1;
            st_r    <= S_ANG;
          end
        end else begin
          pitch_r <= ang_res;
          cflag_r <= 1'b0;
          st_r    <= S_CS0;
        end
      end

      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            func_r <= in_tuser[1:0];
            dir_r  <= in_tdata[1:0];
            dt_r   <= in_tdata[17:2];
            dx_r   <= $signed(in_tdata[33:18]);
            dy_r   <= $signed(in_tdata[49:34]);
            unique case (in_tuser[1:0])
              FUNC_MOVE: st_r <= S_MV0;
              FUNC_LOOK: st_r <= S_LK0;
              FUNC_PLACE: begin
                pos_r[0] <= $signed(in_tdata[81:50]);
                pos_r[1] <= $signed(in_tdata[113:82]);
                pos_r[2] <= $signed(in_tdata[145:114]);
                av_r     <= 32'(syaw_r);
                aflag_r  <= 1'b0;
                st_r     <= S_ANG;
              end
              default: st_r <= S_DONE;
            endcase
          end
        end
        S_MV0: st_r <= S_MV1;
        S_MV1: begin
          shift_r <= prod[31:0];
          k_r     <= 2'd0;
          st_r    <= S_MV2;
        end
        S_MV2: st_r <= S_MV3;
        S_MV3: begin
          if (mv_sum > 34'sh7FFFFFFF) pos_r[k_r] <= 32'sh7FFFFFFF;
          else if (mv_sum < -34'sh80000000) pos_r[k_r] <= 32'sh80000000;
          else pos_r[k_r] <= 32'(mv_sum);
          if (k_r == 2'd2) begin
            st_r <= S_DONE;
          end else begin
            k_r  <= k_r + 2'd1;
            st_r <= S_MV2;
          end
        end
        S_LK0: st_r <= S_LK1;
        S_LK1: begin
          av_r    <= 32'(yaw_r) + lk_r;
          aflag_r <= 1'b0;
          st_r    <= S_ANG;
        end
        S_LK2: st_r <= S_LK3;
        S_LK3: begin
          av_r    <= 32'(pitch_r) + lk_r;
          aflag_r <= 1'b1;
          st_r    <= S_ANG;
        end
        S_ANG: begin
          if (!(aflag_r && clamp_en_r)) begin
            wr_r  <= 32'(av_r) + 32'(HALF_TURN) + (32'(FULL_TURN) << 15);
            cnt_r <= 5'd15;
            st_r  <= S_WRAP;
          end
        end
        S_WRAP: begin
          wr_r <= wr_nxt;
          if (cnt_r != 5'd0) cnt_r <= cnt_r - 5'd1;
        end
        S_CS0: begin
          wx_r  <= 33'(INV_GAIN_Q30);
          wy_r  <= '0;
          wz_r  <= {ang_f[15], ang_f[15:0], 15'd0};
          neg_r <= ang_neg;
          cnt_r <= 5'd0;
          st_r  <= S_CS1;
        end
        S_CS1: begin
          if (!wz_r[31]) begin
            wx_r <= wx_r - cy_sh;
            wy_r <= wy_r + cx_sh;
            wz_r <= wz_r - atan_v;
          end else begin
            wx_r <= wx_r + cy_sh;
            wy_r <= wy_r - cx_sh;
            wz_r <= wz_r + atan_v;
          end
          if (cnt_r == LAST_STEP) st_r <= S_CS2;
          else cnt_r <= cnt_r + 5'd1;
        end
        S_CS2: begin
          if (!cflag_r) begin
            cosy_r  <= neg_r ? -wx_r : wx_r;
            siny_r  <= neg_r ? -wy_r : wy_r;
            cflag_r <= 1'b1;
            st_r    <= S_CS0;
          end else begin
            cosp_r <= neg_r ? -wx_r : wx_r;
            sinp_r <= neg_r ? -wy_r : wy_r;
            st_r   <= S_FR0;
          end
        end
        S_FR0: st_r <= S_FR1;
        S_FR1: begin
          vec_r[0] <= fr_r;
          st_r     <= S_FR2;
        end
        S_FR2: begin
          vec_r[2] <= fr_r;
          vec_r[1] <= 32'(sinp_r);
          k_r      <= 2'd0;
          nsel_r   <= 2'd0;
          st_r     <= S_NSQ;
        end
        S_NSQ: st_r <= S_NAC;
        S_NAC: begin
          if (k_r == 2'd0) sum_r <= prod[63:0];
          else sum_r <= sum_r + prod[63:0];
          if (k_r == 2'd2) begin
            sqn_r   <= sum_r + prod[63:0];
            sqres_r <= '0;
            cnt_r   <= 5'd31;
            st_r    <= S_SQ;
          end else begin
            k_r  <= k_r + 2'd1;
            st_r <= S_NSQ;
          end
        end
        S_SQ: begin
          sqn_r   <= sqn_nxt;
          sqres_r <= sqres_nxt;
          if (cnt_r == 5'd0) begin
            len_r <= sqres_nxt[31:0];
            k_r   <= 2'd0;
            st_r  <= S_DV0;
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        S_DV0: begin
          rem_r <= (47'(vmag) << 14) + 47'(len_r >> 1);
          q_r   <= '0;
          cnt_r <= 5'd14;
          if (len_r == 32'd0) begin
            q_r  <= '0;
            st_r <= S_DV2;
          end else begin
            st_r <= S_DV1;
          end
        end
        S_DV1: begin
          if (rem_r >= dv_trial) begin
            rem_r        <= rem_r - dv_trial;
            q_r[cnt_r[3:0]] <= 1'b1;
          end
          if (cnt_r == 5'd0) st_r <= S_DV2;
          else cnt_r <= cnt_r - 5'd1;
        end
        S_DV2: begin
          case (nsel_r)
            2'd0:    front_r[k_r] <= nq;
            2'd1:    right_r[k_r] <= nq;
            default: up_r[k_r]    <= nq;
          endcase
          if (k_r != 2'd2) begin
            k_r  <= k_r + 2'd1;
            st_r <= S_DV0;
          end else if (nsel_r == 2'd2) begin
            st_r <= S_DONE;
          end else begin
            j_r  <= 3'd0;
            st_r <= S_CRM;
          end
        end
        S_CRM: st_r <= S_CRA;
        S_CRA: begin
          if (!j_r[0]) acc_r <= $signed(prod[31:0]);
          else vec_r[j_r[2:1]] <= acc_r - $signed(prod[31:0]);
          if (j_r == 3'd5) begin
            nsel_r <= nsel_r + 2'd1;
            k_r    <= 2'd0;
            st_r   <= S_NSQ;
          end else begin
            j_r  <= j_r + 3'd1;
            st_r <= S_CRM;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {up_r[2], up_r[1], up_r[0],
                             right_r[2], right_r[1], right_r[0],
                             front_r[2], front_r[1], front_r[0],
                             pos_r[2], pos_r[1], pos_r[0]};
            out_tvalid_r <= 1'b1;
            st_r         <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `EFCU_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `EFCU_ASSERT_NOW(a_div_len_nonzero, st_r == S_DV1, len_r != 32'd0, "divide by zero length")
  `EFCU_ASSERT_NOW(a_yaw_range, 1'b1, yaw_r >= -16'sd23040 && yaw_r <= 16'sd23039, "yaw range")

endmodule
`default_nettype wire

// File: hdl/efcu_mul.sv
`default_nettype none
module efcu_mul (
  input  wire logic                                clk,
  input  wire logic signed [efcu_pkg::MUL_W-1:0]   a,
  input  wire logic signed [efcu_pkg::MUL_W-1:0]   b,
  output logic signed [2*efcu_pkg::MUL_W-1:0]      p_r
);
  import efcu_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
`default_nettype wire
